// File: rtl/core/jiie_pkg.sv
// Package for the intermediate-code instruction executor.
// Holds the operation codes and the field widths; depends on nothing.
`default_nettype none
package jiie_pkg;

    localparam int unsigned OpWidth   = 6;
    localparam int unsigned SlotWidth = 8;
    localparam int unsigned DataWidth = 32;
    localparam int unsigned ThumbBit  = 5;

    typedef enum logic [OpWidth-1:0] {
        OP_LOAD_REG    = 6'd0,
        OP_STORE_REG   = 6'd1,
        OP_LOAD_FLAG   = 6'd2,
        OP_STORE_FLAG  = 6'd3,
        OP_LOAD_CPSR   = 6'd4,
        OP_STORE_CPSR  = 6'd5,
        OP_LOAD_SPSR   = 6'd6,
        OP_STORE_SPSR  = 6'd7,
        OP_LOAD_THUMB  = 6'd8,
        OP_STORE_THUMB = 6'd9,
        OP_NOP         = 6'd10,
        OP_MOV         = 6'd11,
        OP_AND         = 6'd12,
        OP_OR          = 6'd13,
        OP_XOR         = 6'd14,
        OP_NOT         = 6'd15,
        OP_LSL         = 6'd16,
        OP_LSR         = 6'd17,
        OP_ASR         = 6'd18,
        OP_ROR         = 6'd19,
        OP_RRC         = 6'd20,
        OP_ADD         = 6'd21,
        OP_SUB         = 6'd22,
        OP_ADC         = 6'd23,
        OP_SBC         = 6'd24,
        OP_MUL         = 6'd25,
        OP_UMULH       = 6'd26,
        OP_SMULH       = 6'd27,
        OP_SMULW       = 6'd28,
        OP_CLZ         = 6'd29,
        OP_GETN        = 6'd30,
        OP_GETZ        = 6'd31,
        OP_GETC        = 6'd32,
        OP_GETV        = 6'd33,
        OP_SETC        = 6'd34,
        OP_GETCIFZ     = 6'd35,
        OP_PCMASK      = 6'd36,
        OP_JZ          = 6'd37,
        OP_JNZ         = 6'd38,
        OP_JELSE       = 6'd39
    } t_op;

    localparam logic [DataWidth-1:0] PcMaskArm   = ~32'd3;
    localparam logic [DataWidth-1:0] PcMaskThumb = ~32'd1;

endpackage
`default_nettype wire

// File: rtl/core/jit_ir_instruction_executor.sv
// Intermediate-code instruction executor: one instruction per word.
// Execute register, then output register; one word per cycle unless stalled.
// Operand slots are read from the value file at accept; the result is written back
// and forwarded to the next word when it leaves the execute register.
// Reset (synchronous, active low) clears flags, registers, status words and valids;
// the value file is not cleared.
// Depends on jiie_pkg.
`default_nettype none
module jit_ir_instruction_executor #(
    parameter int unsigned VALUE_SLOTS    = 256,
    parameter int unsigned REGISTER_COUNT = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [jiie_pkg::OpWidth-1:0]    i_req_type,
    input  wire logic [jiie_pkg::SlotWidth-1:0]  i_slot,
    input  wire logic [jiie_pkg::DataWidth-1:0]  i_first_operand,
    input  wire logic                            i_first_is_immediate,
    input  wire logic [jiie_pkg::DataWidth-1:0]  i_second_operand,
    input  wire logic                            i_second_is_immediate,
    input  wire logic                            i_update_flags,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [jiie_pkg::DataWidth-1:0]       o_result_value,
    output logic                                 o_result_written,
    output logic                                 o_jump_taken,
    output logic [jiie_pkg::SlotWidth-1:0]       o_jump_target
);
    import jiie_pkg::*;

    localparam int unsigned AW = $clog2(VALUE_SLOTS);
    localparam int unsigned RW = $clog2(REGISTER_COUNT);
    localparam logic [DataWidth-1:0] SlotLimit = DataWidth'(VALUE_SLOTS);

    // value file and its registered read ports
    logic [DataWidth-1:0] r_vf [VALUE_SLOTS];
    logic [DataWidth-1:0] r_rd_a, r_rd_b;

    // execute register
    logic                 r_s1_v;
    logic [OpWidth-1:0]   r_req_type;
    logic [SlotWidth-1:0] r_slot;
    logic                 r_slot_ok;
    logic [DataWidth-1:0] r_op_a, r_op_b;
    logic                 r_imm_a, r_imm_b, r_rng_a, r_rng_b, r_fwd_a, r_fwd_b;
    logic                 r_upd;
    logic [DataWidth-1:0] r_fwd_val;

    // architectural state
    logic                 r_carry, r_ovf, r_last_jt;
    logic [DataWidth-1:0] r_gpr [REGISTER_COUNT];
    logic [DataWidth-1:0] r_cpsr, r_spsr;

    // output register
    logic                 r_o_v;
    logic [DataWidth-1:0] r_res;
    logic                 r_has, r_jt;
    logic [SlotWidth-1:0] r_jtgt;

    logic                 w_out_free, w_adv, w_acc, w_we;
    logic [DataWidth-1:0] w_a, w_b, w_bx, w_res, n_cpsr, n_spsr;
    logic                 w_has, w_jt, w_jop, w_cin, n_carry, n_ovf, w_gpr_we;
    logic [DataWidth:0]   w_sum;
    logic [4:0]           w_sh, w_fbit;
    logic [2*DataWidth+1:0] w_prod;
    logic [5:0]           w_clz;

    // handshake: execute register drains into output register
    assign w_out_free = !r_o_v || !i_stall;
    assign w_adv      = r_s1_v && w_out_free;
    assign o_stall    = r_s1_v && !w_out_free;
    assign w_acc      = i_valid && !o_stall;
    assign w_we       = w_adv && w_has && r_slot_ok;

    // select operands: literal, out of range, forwarded or read from file
    always_comb begin
        if (r_imm_a)      w_a = r_op_a;
        else if (!r_rng_a) w_a = '0;
        else if (r_fwd_a)  w_a = r_fwd_val;
        else               w_a = r_rd_a;
        if (r_imm_b)      w_b = r_op_b;
        else if (!r_rng_b) w_b = '0;
        else if (r_fwd_b)  w_b = r_fwd_val;
        else               w_b = r_rd_b;
    end

    // shared adder, multiplier and leading-zero count
    always_comb begin
        unique case (t_op'(r_req_type))
            OP_SUB, OP_SBC: w_bx = ~w_b;
            default:        w_bx = w_b;
        endcase
        unique case (t_op'(r_req_type))
            OP_SUB:         w_cin = 1'b1;
            OP_ADC, OP_SBC: w_cin = r_carry;
            default:        w_cin = 1'b0;
        endcase
        w_sum  = {1'b0, w_a} + {1'b0, w_bx} + {{DataWidth{1'b0}}, w_cin};
        w_prod = 66'($signed({(r_req_type != OP_UMULH) && w_a[31], w_a})
                   * $signed({(r_req_type != OP_UMULH) && w_b[31], w_b}));
        w_clz  = 6'd32;
        for (int i = 0; i < 32; i++) begin
            if (w_b[i]) w_clz = 6'(31 - i);
        end
        w_sh   = (w_b >= 32'd32) ? 5'd31 : w_b[4:0];
        w_fbit = ~w_a[4:0];
    end

    // execute one operation
    always_comb begin
        w_res    = '0;
        w_has    = 1'b1;
        w_jt     = 1'b0;
        w_jop    = 1'b0;
        w_gpr_we = 1'b0;
        n_cpsr   = r_cpsr;
        n_spsr   = r_spsr;
        n_carry  = r_carry;
        n_ovf    = r_ovf;
        unique case (t_op'(r_req_type))
            OP_LOAD_REG:    w_res = r_gpr[w_a[RW-1:0]];
            OP_STORE_REG:   begin w_gpr_we = 1'b1; w_has = 1'b0; end
            OP_LOAD_FLAG:   w_res = {31'd0, r_cpsr[w_fbit]};
            OP_STORE_FLAG:  begin n_cpsr[w_fbit] = (w_b != '0); w_has = 1'b0; end
            OP_LOAD_CPSR:   w_res = r_cpsr;
            OP_STORE_CPSR:  begin n_cpsr = w_b; w_has = 1'b0; end
            OP_LOAD_SPSR:   w_res = r_spsr;
            OP_STORE_SPSR:  begin n_spsr = w_b; w_has = 1'b0; end
            OP_LOAD_THUMB:  w_res = {31'd0, r_cpsr[ThumbBit]};
            OP_STORE_THUMB: begin n_cpsr[ThumbBit] = w_b[0]; w_has = 1'b0; end
            OP_NOP:         w_has = 1'b0;
            OP_MOV:         w_res = w_b;
            OP_AND:         w_res = w_a & w_b;
            OP_OR:          w_res = w_a | w_b;
            OP_XOR:         w_res = w_a ^ w_b;
            OP_NOT:         w_res = ~w_b;
            OP_LSL:         w_res = (w_b >= 32'd32) ? '0 : (w_a << w_b[4:0]);
            OP_LSR:         w_res = (w_b >= 32'd32) ? '0 : (w_a >> w_b[4:0]);
            OP_ASR:         w_res = $unsigned($signed(w_a) >>> w_sh);
            OP_ROR:         w_res = 32'({w_a, w_a} >> w_b[4:0]);
            OP_RRC:         w_res = {r_carry, w_a[31:1]};
            OP_ADD, OP_SUB, OP_ADC, OP_SBC: begin
                w_res = w_sum[DataWidth-1:0];
                if (r_upd) begin
                    n_carry = w_sum[DataWidth];
                    n_ovf   = (w_a[31] ^ w_sum[31]) & ~(w_a[31] ^ w_bx[31]);
                end
            end
            OP_MUL:         w_res = w_prod[31:0];
            OP_UMULH,
            OP_SMULH:       w_res = w_prod[63:32];
            OP_SMULW:       w_res = w_prod[47:16];
            OP_CLZ:         w_res = {26'd0, w_clz};
            OP_GETN:        w_res = {31'd0, w_b[31]};
            OP_GETZ:        w_res = {31'd0, w_b == '0};
            OP_GETC:        w_res = {31'd0, r_carry};
            OP_GETV:        w_res = {31'd0, r_ovf};
            OP_SETC:        begin n_carry = (w_b != '0); w_has = 1'b0; end
            OP_GETCIFZ:     w_res = (w_a != '0) ? w_b : {31'd0, r_carry};
            OP_PCMASK:      w_res = (w_a != '0) ? PcMaskThumb : PcMaskArm;
            OP_JZ:          begin w_jop = 1'b1; w_jt = (w_a == '0); w_has = 1'b0; end
            OP_JNZ:         begin w_jop = 1'b1; w_jt = (w_a != '0); w_has = 1'b0; end
            OP_JELSE:       begin w_jop = 1'b1; w_jt = !r_last_jt; w_has = 1'b0; end
            default:        w_has = 1'b0;
        endcase
        if (!w_has) w_res = '0;
    end

    // value file: write on retire, read on accept
    always_ff @(posedge i_clk) begin
        if (w_we) r_vf[AW'(r_slot)] <= w_res;
        if (w_acc) begin
            r_rd_a <= r_vf[i_first_operand[AW-1:0]];
            r_rd_b <= r_vf[i_second_operand[AW-1:0]];
        end
    end

    // capture incoming word and forwarding marks; load the output register on advance
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_req_type <= i_req_type;
            r_slot     <= i_slot;
            r_slot_ok  <= {24'd0, i_slot} < SlotLimit;
            r_op_a     <= i_first_operand;
            r_op_b     <= i_second_operand;
            r_imm_a    <= i_first_is_immediate;
            r_imm_b    <= i_second_is_immediate;
            r_rng_a    <= i_first_operand < SlotLimit;
            r_rng_b    <= i_second_operand < SlotLimit;
            r_fwd_a    <= w_we && (i_first_operand == {24'd0, r_slot});
            r_fwd_b    <= w_we && (i_second_operand == {24'd0, r_slot});
            r_upd      <= i_update_flags;
            r_fwd_val  <= w_res;
        end
        if (w_adv) begin
            r_res  <= w_res;
            r_has  <= w_has;
            r_jt   <= w_jt;
            r_jtgt <= w_jt ? w_b[SlotWidth-1:0] : '0;
        end
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v    <= 1'b0;
            r_o_v     <= 1'b0;
            r_carry   <= 1'b0;
            r_ovf     <= 1'b0;
            r_last_jt <= 1'b0;
            r_cpsr    <= '0;
            r_spsr    <= '0;
            for (int i = 0; i < REGISTER_COUNT; i++) r_gpr[i] <= '0;
        end else begin
            if (w_acc)           r_s1_v <= 1'b1;
            else if (w_adv)      r_s1_v <= 1'b0;
            if (w_out_free)      r_o_v  <= r_s1_v;
            if (w_adv) begin
                r_carry <= n_carry;
                r_ovf   <= n_ovf;
                r_cpsr  <= n_cpsr;
                r_spsr  <= n_spsr;
                if (w_jop)    r_last_jt <= w_jt;
                if (w_gpr_we) r_gpr[w_a[RW-1:0]] <= w_b;
            end
        end
    end

    assign o_valid          = r_o_v;
    assign o_result_value   = r_res;
    assign o_result_written = r_has;
    assign o_jump_taken     = r_jt;
    assign o_jump_target    = r_jtgt;

endmodule
`default_nettype wire

// File: sim/tb_top.sv
// Testbench for the intermediate-code instruction executor.
// Holds its own model of the executor and checks every result word in order.
// Depends on jiie_pkg and jit_ir_instruction_executor.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import jiie_pkg::*;

    typedef struct packed {
        logic [OpWidth-1:0]   op;
        logic [SlotWidth-1:0] slot;
        logic [DataWidth-1:0] a;
        logic                 a_imm;
        logic [DataWidth-1:0] b;
        logic                 b_imm;
        logic                 upd;
        logic                 drain;   // hold until every result is back
    } t_instr;

    typedef struct packed {
        logic [DataWidth-1:0] value;
        logic                 written;
        logic                 jt;
        logic [SlotWidth-1:0] target;
    } t_outcome;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic vld = 1'b0;
    logic rdy_stall = 1'b0;
    logic dut_stall, dut_vld;
    t_instr cur = '0;
    logic [DataWidth-1:0] res_value;
    logic res_written, res_jt;
    logic [SlotWidth-1:0] res_target;

    t_instr   pending_words[$];
    t_outcome expected_results[$];
    logic     accepted = 1'b0;
    int       errors = 0;
    int       cycles = 0;

    // Executor state mirror
    logic [DataWidth-1:0] vfile [256];
    logic [DataWidth-1:0] gregs [16];
    logic                 carry, ovf, last_jt;
    logic [DataWidth-1:0] status, saved_status;

    // Slots the stimulus has already filled
    bit   slot_filled [256];
    int   filled_list[$];

    always #1 clk = ~clk;

    jit_ir_instruction_executor u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(vld), .o_stall(dut_stall),
        .i_req_type(cur.op), .i_slot(cur.slot),
        .i_first_operand(cur.a), .i_first_is_immediate(cur.a_imm),
        .i_second_operand(cur.b), .i_second_is_immediate(cur.b_imm),
        .i_update_flags(cur.upd),
        .o_valid(dut_vld), .i_stall(rdy_stall),
        .o_result_value(res_value), .o_result_written(res_written),
        .o_jump_taken(res_jt), .o_jump_target(res_target)
    );

    function automatic logic [DataWidth-1:0] operand(logic [DataWidth-1:0] raw, logic imm);
        if (imm) return raw;
        if (raw < 256) return vfile[raw[7:0]];
        return '0;
    endfunction

    function automatic logic [DataWidth-1:0] add_carry(logic [DataWidth-1:0] x,
                                                       logic [DataWidth-1:0] y,
                                                       logic c, logic upd);
        logic [DataWidth:0] sum;
        sum = {1'b0, x} + {1'b0, y} + c;
        if (upd) begin
            carry = sum[DataWidth];
            ovf = ((x ^ sum[31:0]) & ~(x ^ y)) >> 31;
        end
        return sum[31:0];
    endfunction

    // Execute one instruction against the mirror and return its result word
    function automatic t_outcome exec_instr(t_instr w);
        t_outcome o;
        logic [DataWidth-1:0] a, b, r;
        logic [4:0] bitn;
        logic signed [63:0] prod;
        logic [63:0] uprod;
        logic has, jt, jump_op;
        int n;
        a = operand(w.a, w.a_imm);
        b = operand(w.b, w.b_imm);
        r = '0; has = 1'b1; jt = 1'b0; jump_op = 1'b0;
        bitn = 5'd31 - a[4:0];
        prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
        uprod = {32'd0, a} * {32'd0, b};
        case (w.op)
            OP_LOAD_REG:    r = gregs[a[3:0]];
            OP_STORE_REG:   begin gregs[a[3:0]] = b; has = 1'b0; end
            OP_LOAD_FLAG:   r = {31'd0, status[bitn]};
            OP_STORE_FLAG:  begin status[bitn] = (b != 0); has = 1'b0; end
            OP_LOAD_CPSR:   r = status;
            OP_STORE_CPSR:  begin status = b; has = 1'b0; end
            OP_LOAD_SPSR:   r = saved_status;
            OP_STORE_SPSR:  begin saved_status = b; has = 1'b0; end
            OP_LOAD_THUMB:  r = {31'd0, status[ThumbBit]};
            OP_STORE_THUMB: begin status[ThumbBit] = b[0]; has = 1'b0; end
            OP_MOV:         r = b;
            OP_AND:         r = a & b;
            OP_OR:          r = a | b;
            OP_XOR:         r = a ^ b;
            OP_NOT:         r = ~b;
            OP_LSL:         r = (b >= 32) ? '0 : a << b[4:0];
            OP_LSR:         r = (b >= 32) ? '0 : a >> b[4:0];
            OP_ASR:         r = $signed(a) >>> ((b >= 32) ? 31 : b[4:0]);
            OP_ROR:         r = (b[4:0] == 0) ? a : ((a >> b[4:0]) | (a << (32 - b[4:0])));
            OP_RRC:         r = {carry, a[31:1]};
            OP_ADD:         r = add_carry(a, b, 1'b0, w.upd);
            OP_SUB:         r = add_carry(a, ~b, 1'b1, w.upd);
            OP_ADC:         r = add_carry(a, b, carry, w.upd);
            OP_SBC:         r = add_carry(a, ~b, carry, w.upd);
            OP_MUL:         r = uprod[31:0];
            OP_UMULH:       r = uprod[63:32];
            OP_SMULH:       r = prod[63:32];
            OP_SMULW:       r = prod[47:16];
            OP_CLZ: begin
                n = 0;
                while (n < 32 && !b[31 - n]) n++;
                r = n;
            end
            OP_GETN:        r = {31'd0, b[31]};
            OP_GETZ:        r = {31'd0, b == 0};
            OP_GETC:        r = {31'd0, carry};
            OP_GETV:        r = {31'd0, ovf};
            OP_SETC:        begin carry = (b != 0); has = 1'b0; end
            OP_GETCIFZ:     r = (a != 0) ? b : {31'd0, carry};
            OP_PCMASK:      r = (a != 0) ? PcMaskThumb : PcMaskArm;
            OP_JZ:          begin jump_op = 1'b1; jt = (a == 0); has = 1'b0; end
            OP_JNZ:         begin jump_op = 1'b1; jt = (a != 0); has = 1'b0; end
            OP_JELSE:       begin jump_op = 1'b1; jt = !last_jt; has = 1'b0; end
            default:        has = 1'b0;
        endcase
        if (jump_op) last_jt = jt;
        if (has) vfile[w.slot] = r;
        o.value = has ? r : '0;
        o.written = has;
        o.jt = jt;
        o.target = jt ? b[7:0] : '0;
        return o;
    endfunction

    function automatic bit makes_value(logic [OpWidth-1:0] op);
        if (op > OP_JELSE) return 0;
        return !(op inside {OP_STORE_REG, OP_STORE_FLAG, OP_STORE_CPSR, OP_STORE_SPSR,
                            OP_STORE_THUMB, OP_NOP, OP_SETC, OP_JZ, OP_JNZ, OP_JELSE});
    endfunction

    task automatic queue_word(logic [OpWidth-1:0] op, logic [SlotWidth-1:0] slot,
                              logic [DataWidth-1:0] a, logic a_imm,
                              logic [DataWidth-1:0] b, logic b_imm, logic upd,
                              logic drain = 1'b0);
        t_instr w;
        w = '{op, slot, a, a_imm, b, b_imm, upd, drain};
        pending_words.push_back(w);
        if (makes_value(op) && !slot_filled[slot]) begin
            slot_filled[slot] = 1;
            filled_list.push_back(slot);
        end
    endtask

    // Pick an operand: a filled slot, an index past the file, or a literal
    task automatic pick_operand(output logic [DataWidth-1:0] v, output logic imm,
                                input bit shift_amt);
        int k;
        k = $urandom_range(0, 9);
        imm = 1'b1;
        if (k < 4 && filled_list.size() > 0) begin
            v = filled_list[$urandom_range(0, filled_list.size() - 1)];
            imm = 1'b0;
        end else if (k == 4) begin
            v = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom_range(256, 100000);
            imm = 1'b0;
        end else if (shift_amt && k < 8) begin
            v = $urandom_range(0, 40);
        end else begin
            case ($urandom_range(0, 5))
                0: v = '0;
                1: v = 32'hFFFF_FFFF;
                2: v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                3: v = $urandom_range(0, 40);
                default: v = $urandom;
            endcase
        end
    endtask

    task automatic queue_random(logic [OpWidth-1:0] op, logic drain = 1'b0);
        logic [DataWidth-1:0] a, b;
        logic ai, bi;
        pick_operand(a, ai, 1'b0);
        pick_operand(b, bi, op inside {OP_LSL, OP_LSR, OP_ASR, OP_ROR});
        queue_word(op, 8'($urandom_range(0, 255)), a, ai, b, bi,
                   1'($urandom_range(0, 1)), drain);
    endtask

    // Stimulus: directed corners, then random words and short flag/jump chains
    initial begin
        int i;
        logic [OpWidth-1:0] op;
        for (i = 0; i < 16; i++) gregs[i] = '0;
        for (i = 0; i < 256; i++) vfile[i] = '0;
        carry = 0; ovf = 0; last_jt = 0; status = '0; saved_status = '0;

        queue_word(OP_MOV, 8'd0, 0, 1, 32'hFFFF_FFFF, 1, 0);
        queue_word(OP_MOV, 8'd1, 0, 1, 32'h8000_0000, 1, 0);
        queue_word(OP_ADD, 8'd2, 0, 0, 32'd1, 1, 1);
        queue_word(OP_GETC, 8'd3, 0, 1, 0, 1, 0);
        queue_word(OP_SUB, 8'd4, 1, 0, 32'd1, 1, 1);
        queue_word(OP_GETV, 8'd5, 0, 1, 0, 1, 0);
        queue_word(OP_ADD, 8'd6, 0, 0, 0, 0, 0);
        queue_word(OP_LSL, 8'd7, 0, 0, 32'd32, 1, 0);
        queue_word(OP_LSR, 8'd8, 0, 0, 32'd40, 1, 0);
        queue_word(OP_ASR, 8'd9, 1, 0, 32'd100, 1, 0);
        queue_word(OP_ROR, 8'd10, 32'h1234_5678, 1, 32'd0, 1, 0);
        queue_word(OP_ROR, 8'd11, 32'h1234_5678, 1, 32'd33, 1, 0);
        queue_word(OP_CLZ, 8'd12, 0, 1, 32'd0, 1, 0);
        queue_word(OP_STORE_FLAG, 8'd13, 32'd33, 1, 32'd1, 1, 0);
        queue_word(OP_LOAD_FLAG, 8'd14, 32'd1, 1, 0, 1, 0);
        queue_word(OP_STORE_REG, 8'd15, 32'hFFFF_FFFF, 1, 32'hDEAD_BEEF, 1, 0);
        queue_word(OP_LOAD_REG, 8'd16, 32'd15, 1, 0, 1, 0);
        queue_word(OP_AND, 8'd17, 32'd300, 0, 32'hFFFF_FFFF, 1, 0);
        queue_word(OP_SMULH, 8'd18, 0, 0, 1, 0, 0);
        queue_word(OP_SMULW, 8'd19, 1, 0, 32'h7FFF_FFFF, 1, 0);
        queue_word(OP_JZ, 8'd20, 32'd0, 1, 32'hFFFF_FFA5, 1, 0);
        queue_word(OP_JELSE, 8'd21, 0, 1, 32'd7, 1, 0);
        queue_word(6'd63, 8'd22, 0, 1, 0, 1, 1, 1'b1);
        queue_word(OP_STORE_THUMB, 8'd23, 0, 1, 32'd1, 1, 0);
        queue_word(OP_PCMASK, 8'd24, 32'd0, 1, 0, 1, 0);

        for (i = 0; i < 1060; i++) begin
            case ($urandom_range(0, 9))
                0: begin
                    // flag producer followed by a flag consumer
                    queue_word(6'($urandom_range(OP_ADD, OP_SBC)),
                               8'($urandom_range(0, 255)),
                               $urandom, 1, $urandom, 1, 1'b1);
                    op = 6'($urandom_range(0, 3));
                    queue_random(op == 0 ? OP_GETC : op == 1 ? OP_GETV :
                                 op == 2 ? OP_RRC : OP_ADC);
                end
                1: begin
                    queue_random(6'($urandom_range(OP_JZ, OP_JNZ)));
                    queue_random(OP_JELSE);
                end
                2: queue_random(6'($urandom_range(40, 63)));
                default: queue_random(6'($urandom_range(0, 39)), i == 530);
            endcase
        end
    end

    // Driver: bursts with gaps, one new word per accept
    int burst_left = 4;
    int gap_left = 0;
    always @(negedge clk) begin
        if (rst_n && !(vld && !accepted)) begin
            if (gap_left > 0) begin
                vld <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_words.size() > 0 &&
                         !(pending_words[0].drain && (expected_results.size() > 0 ||
                                                      (vld && !accepted)))) begin
                cur <= pending_words.pop_front();
                vld <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                vld <= 1'b0;
            end
        end
    end

    // Receiver stall pattern: one of four stall modes, redrawn periodically
    int stall_mode = 0;
    always @(negedge clk) begin
        if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: rdy_stall <= 1'b0;
            1: rdy_stall <= ($urandom_range(0, 3) == 0);
            2: rdy_stall <= ($urandom_range(0, 3) != 0);
            default: rdy_stall <= (cycles % 3 == 0);
        endcase
    end

    // Monitor: check the result word, then predict the accepted word
    always @(posedge clk) begin
        t_outcome got, exp_o;
        cycles <= cycles + 1;
        if (rst_n && dut_vld && !rdy_stall) begin
            got = '{res_value, res_written, res_jt, res_target};
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, got);
                errors++;
            end else begin
                exp_o = expected_results.pop_front();
                if (got.value !== exp_o.value) begin
                    $display("%0t: result_value expected %h actual %h",
                             $time, exp_o.value, got.value);
                    errors++;
                end
                if (got.written !== exp_o.written) begin
                    $display("%0t: result_written expected %b actual %b",
                             $time, exp_o.written, got.written);
                    errors++;
                end
                if (got.jt !== exp_o.jt) begin
                    $display("%0t: jump_taken expected %b actual %b",
                             $time, exp_o.jt, got.jt);
                    errors++;
                end
                if (got.target !== exp_o.target) begin
                    $display("%0t: jump_target expected %h actual %h",
                             $time, exp_o.target, got.target);
                    errors++;
                end
            end
        end
        accepted <= rst_n && vld && !dut_stall;
        if (rst_n && vld && !dut_stall) expected_results.push_back(exec_instr(cur));
    end

    // Reset, drain and final verdict
    initial begin
        repeat (9) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
        wait (pending_words.size() == 0);
        @(posedge clk);
        while (vld && !accepted) @(posedge clk);
        while (expected_results.size() > 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("** jit_ir_instruction_executor: PASSED **");
        end else begin
            $display("** jit_ir_instruction_executor: FAILED **");
        end
        $finish;
    end

    // Watchdog
    always @(posedge clk) begin
        if (cycles > 200000) begin
            $display("** jit_ir_instruction_executor: FAILED **");
            $finish;
        end
    end
endmodule
`default_nettype wire

// File: sim.f
rtl/core/jiie_pkg.sv
rtl/core/jit_ir_instruction_executor.sv
sim/tb_top.sv
